/* design/aes_pkg.sv */
// shared types, constants and round functions for the aes block encryptor
package aes_pkg;

   localparam int MaxRounds = 14;
   localparam int KeyWords  = 2 * (MaxRounds + 1);
   localparam int KeyIdxW   = $clog2(KeyWords);
   localparam int RoundW    = $clog2(MaxRounds + 1);
   localparam logic [RoundW-1:0] Rounds128 = RoundW'(10);
   localparam logic [RoundW-1:0] Rounds256 = RoundW'(14);

   localparam logic OpKey  = 1'b0;
   localparam logic OpData = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_OUT0,
      ST_OUT1
   } state_type;

   typedef struct packed {
      logic start;
      logic rk_lo;
      logic rk_hi;
      logic do_round;
      logic last_round;
      logic final_add;
   } cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits [127-8i -: 8]
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[r+4*c] = SBOX[b[r + 4*((c+r)%4)]];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
      return o;
   endfunction

endpackage

/* design/aes_datapath.sv */
// key store, state register and round logic of the aes encryptor
module aes_datapath import aes_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               key_we,
   input  logic [KeyIdxW-1:0] key_waddr,
   input  logic [63:0]        in_data,
   input  logic               pend_we,
   input  logic [KeyIdxW-1:0] key_raddr,
   input  cmd_type            cmd,
   input  logic               out_sel,
   output logic [63:0]        cipher_word
);

   logic [63:0]  key_mem [KeyWords];
   logic [63:0]  rk_lo_ff, rk_hi_ff;
   logic [63:0]  rk_rd_ff;
   logic [63:0]  pend_ff, second_ff;
   logic [127:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_waddr] <= in_data;
      rk_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else if (pend_we) pend_ff <= in_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) second_ff <= in_data;
      if (cmd.rk_lo) rk_lo_ff <= rk_rd_ff;
      if (cmd.rk_hi) rk_hi_ff <= rk_rd_ff;
      state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      if (cmd.do_round)
         state_in = aes_round((cmd.final_add ? state_ff : {pend_ff, second_ff})
                              ^ {rk_lo_ff, rk_hi_ff}, !cmd.last_round);
      else if (cmd.final_add)
         state_in = state_ff ^ {rk_lo_ff, rk_hi_ff};
   end

   assign cipher_word = out_sel ? state_ff[63:0] : state_ff[127:64];

endmodule

/* design/aes_controller.sv */
// sequencer for key reads, rounds and output beats
module aes_controller import aes_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               mode,
   input  logic               out_ready,
   output logic               busy,
   output logic [KeyIdxW-1:0] key_raddr,
   output cmd_type            cmd,
   output logic               out_valid,
   output logic               out_sel
);

   state_type         state_ff, state_in;
   logic [RoundW-1:0] rnd_ff, rnd_in, nr_ff, nr_in;
   logic [1:0]        ph_ff, ph_in;
   logic              first_ff, first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         nr_ff    <= '0;
         ph_ff    <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         nr_ff    <= nr_in;
         ph_ff    <= ph_in;
         first_ff <= first_in;
      end
   end

   // phases: 0 read lo, 1 latch lo and read hi, 2 latch hi, 3 compute
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      nr_in    = nr_ff;
      ph_in    = ph_ff;
      first_in = first_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ROUND;
               rnd_in   = '0;
               ph_in    = '0;
               first_in = 1'b1;
               nr_in    = mode ? Rounds256 : Rounds128;
            end
         end
         ST_ROUND: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd3) begin
               first_in = 1'b0;
               if (rnd_ff == nr_ff) state_in = ST_OUT0;
               else rnd_in = rnd_ff + RoundW'(1);
            end
         end
         ST_OUT0: if (out_ready) state_in = ST_OUT1;
         ST_OUT1: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.start = (state_ff == ST_IDLE) && start;
      key_raddr = KeyIdxW'({rnd_ff, 1'b0}) | KeyIdxW'(ph_ff != 2'd0);
      busy      = state_ff != ST_IDLE;
      out_valid = (state_ff == ST_OUT0) || (state_ff == ST_OUT1);
      out_sel   = state_ff == ST_OUT1;
      case (state_ff)
         ST_ROUND: begin
            cmd.rk_lo = ph_ff == 2'd1;
            cmd.rk_hi = ph_ff == 2'd2;
            if (ph_ff == 2'd3) begin
               cmd.do_round   = rnd_ff != nr_ff;
               cmd.last_round = rnd_ff == nr_ff - RoundW'(1);
               cmd.final_add  = !first_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

/* design/aes_block_encrypt.sv */
// top level of the aes-128/256 block encryptor
//  channel | dir | beat fields
//  req     | in  | tdata: word_data; tuser: operation, word_index
//  rsp     | out | tdata: cipher_word; tlast: word_last
//  csr     | in  | key_length_mode
// a key word or first half is stored when it is accepted
// a second half runs through the round sequencer, each step being key reads,
// key latches and one round of logic or the final key add, then two beats out
// req_tready is low while a block is in flight; rsp stalls hold the state
// reset clears control, mode and pending half; key store is undefined until written
module aes_block_encrypt import aes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // word_data
   input  logic [5:0]  req_tuser,   // operation, word_index[4:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // cipher_word
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic               mode_ff;
   logic               busy, acc, out_sel, start;
   logic [KeyIdxW-1:0] key_raddr;
   cmd_type            cmd;
   logic               op;
   logic [4:0]         idx;

   assign op  = req_tuser[0];
   assign idx = req_tuser[5:1];
   assign req_tready = !busy;
   assign acc   = req_tvalid && req_tready;
   assign start = acc && (op == OpData) && (idx == 5'd1);

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_we) mode_ff <= csr_wdata;
   end

   aes_controller u_ctrl (
      .clock, .reset, .start, .mode(mode_ff), .out_ready(rsp_tready),
      .busy, .key_raddr, .cmd, .out_valid(rsp_tvalid), .out_sel
   );

   aes_datapath u_dp (
      .clock,
      .reset,
      .key_we(acc && (op == OpKey) && (idx < 5'(KeyWords))),
      .key_waddr(KeyIdxW'(idx)),
      .in_data(req_tdata),
      .pend_we(acc && (op == OpData) && (idx == 5'd0)),
      .key_raddr, .cmd, .out_sel,
      .cipher_word(rsp_tdata)
   );

   assign rsp_tlast = out_sel;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("accepted while busy");
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second beat missing");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |=> busy && !rsp_tvalid) else $error("start did not run");

endmodule

/* dv/tb_aes_block_encrypt.sv */
// testbench for aes_block_encrypt: predicted ciphertext checked beat by beat under random idling
module tb_aes_block_encrypt;
   import aes_pkg::*;

   typedef struct {
      logic [63:0] word;
      logic        last;
   } cipher_beat_t;

   class cipher_scoreboard;
      logic [63:0]  key_words [KeyWords];
      logic [63:0]  first_half;
      bit           long_key;
      cipher_beat_t cipher_q [$];

      function new();
         first_half = '0;
         long_key = 0;
         foreach (key_words[i]) key_words[i] = '0;
      endfunction

      function logic [7:0] gmul2(logic [7:0] x);
         return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      endfunction

      function logic [127:0] one_round(logic [127:0] s, bit mix);
         logic [7:0] b [16];
         logic [7:0] t [16];
         logic [7:0] x0, x1, x2, x3, sum;
         logic [127:0] o;
         for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[4*c+r] = SBOX[b[4*((c+r)&3)+r]];
         if (mix) begin
            for (int c = 0; c < 4; c++) begin
               x0 = t[4*c]; x1 = t[4*c+1]; x2 = t[4*c+2]; x3 = t[4*c+3];
               sum = x0 ^ x1 ^ x2 ^ x3;
               t[4*c]   = x0 ^ sum ^ gmul2(x0 ^ x1);
               t[4*c+1] = x1 ^ sum ^ gmul2(x1 ^ x2);
               t[4*c+2] = x2 ^ sum ^ gmul2(x2 ^ x3);
               t[4*c+3] = x3 ^ sum ^ gmul2(x3 ^ x0);
            end
         end
         for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
         return o;
      endfunction

      function void note_input(logic op, logic [4:0] idx, logic [63:0] data);
         logic [127:0] s;
         int nr;
         if (op == OpKey) begin
            if (idx < KeyWords) key_words[idx] = data;
            return;
         end
         if (idx == 0) begin
            first_half = data;
            return;
         end
         if (idx != 1) return;
         nr = long_key ? 14 : 10;
         s = {first_half, data};
         for (int r = 0; r < nr; r++) begin
            s ^= {key_words[2*r], key_words[2*r+1]};
            s = one_round(s, r != nr - 1);
         end
         s ^= {key_words[2*nr], key_words[2*nr+1]};
         cipher_q.push_back('{s[127:64], 1'b0});
         cipher_q.push_back('{s[63:0], 1'b1});
      endfunction

      function bit check_result(logic [63:0] word, logic last, output string msg);
         cipher_beat_t e;
         if (cipher_q.size() == 0) begin
            $sformat(msg, "unexpected beat %h last %b", word, last);
            return 0;
         end
         e = cipher_q.pop_front();
         if (word !== e.word || last !== e.last) begin
            $sformat(msg, "beat %h last %b, expected %h last %b", word, last, e.word, e.last);
            return 0;
         end
         return 1;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [5:0]  req_tuser = '0;   // operation, word_index[4:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;        // cipher_word
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic        csr_wdata = 0;

   cipher_scoreboard sb = new();
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_stall = 0;

   aes_block_encrypt u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > 1000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      string msg;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            if (!sb.check_result(rsp_tdata, rsp_tlast, msg)) report(msg);
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic send_word(logic op, logic [4:0] idx, logic [63:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= {idx, op};
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(op, idx, data);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.cipher_q.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_key_length(bit m);
      drain();
      csr_we <= 1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 0;
      sb.long_key = m;
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic random_items(int n);
      int k;
      logic [63:0] w;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 60) begin
            w = rand_word();
            send_word(OpData, 5'd0, w);
            send_word(OpData, 5'd1, rand_word());
            i++;
         end else if (k < 85) begin
            send_word(OpKey, 5'($urandom_range(31)), rand_word());
         end else if (k < 93) begin
            send_word(OpData, 5'd1, rand_word());
         end else begin
            send_word(OpData, 5'($urandom_range(31, 2)), rand_word());
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int i = 0; i < KeyWords; i++)
         send_word(OpKey, 5'(i), i == 0 ? 64'h0 : i == 1 ? '1 : {$urandom, $urandom});
      // directed corners
      send_word(OpData, 5'd1, '1);
      send_word(OpData, 5'd0, '0);
      send_word(OpData, 5'd1, '1);
      send_word(OpData, 5'd0, '1);
      send_word(OpData, 5'd1, '0);
      send_word(OpData, 5'd31, '1);
      send_word(OpData, 5'd2, 64'h0123456789abcdef);
      send_word(OpKey, 5'd30, '1);
      send_word(OpKey, 5'd31, '1);
      send_word(OpData, 5'd1, 64'h8899aabbccddeeff);
      set_key_length(1);
      send_word(OpData, 5'd0, 64'h0011223344556677);
      send_word(OpData, 5'd1, 64'h8899aabbccddeeff);
      send_word(OpKey, 5'd29, '1);
      send_word(OpKey, 5'd28, '0);
      send_word(OpData, 5'd1, '1);

      for (int p = 0; p < 8; p++) begin
         set_key_length(p % 3 != 0);
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 74; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 74; end
            default: begin send_idle = 17; recv_stall = 17; end
         endcase
         random_items(135);
      end

      drain();
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
